// ===== sv/pfci_pkg.sv =====
// ----------------------------------------------------------------------------
// pfci_pkg: shared types and constants of the flash command interface
// Payload structs, command mode codes, sequencer states and the command
// bytes of the unlock and command sequences.
// ----------------------------------------------------------------------------
package pfci_pkg;

  typedef struct packed {
    logic        req_type;
    logic [18:0] bus_addr;
    logic [7:0]  write_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       modified;
    logic [3:0] mode;
  } res_t;

  typedef enum logic [3:0] {
    M_READ       = 4'd0,
    M_UNLK1      = 4'd1,
    M_UNLK2      = 4'd2,
    M_AUTOSEL    = 4'd3,
    M_PROG       = 4'd4,
    M_PROGRAMMED = 4'd5,
    M_PROG_ERR   = 4'd6,
    M_EUNLK1     = 4'd7,
    M_EUNLK2     = 4'd8,
    M_ESELECT    = 4'd9,
    M_CHIP_ERASE = 4'd10,
    M_SECT_ERASE = 4'd11,
    M_SUSPENDED  = 4'd12
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SWEEP
  } seq_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic exec;
    logic sweep_step;
  } ctrl_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic erase_req;
    logic sweep_last;
  } dp_status_t;

  localparam logic [2:0] CFG_U1_MASK = 3'd0;
  localparam logic [2:0] CFG_U1_ADDR = 3'd1;
  localparam logic [2:0] CFG_U2_MASK = 3'd2;
  localparam logic [2:0] CFG_U2_ADDR = 3'd3;
  localparam logic [2:0] CFG_MAKER   = 3'd4;
  localparam logic [2:0] CFG_PART    = 3'd5;

  localparam logic [7:0] CMD_UNLOCK_A = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK_B = 8'h55;
  localparam logic [7:0] CMD_AUTOSEL  = 8'h90;
  localparam logic [7:0] CMD_PROGRAM  = 8'hA0;
  localparam logic [7:0] CMD_ERASE    = 8'h80;
  localparam logic [7:0] CMD_CHIP     = 8'h10;
  localparam logic [7:0] CMD_SECTOR   = 8'h30;
  localparam logic [7:0] CMD_SUSPEND  = 8'hB0;
  localparam logic [7:0] CMD_EXIT     = 8'hF0;

  localparam logic [7:0] AS_MAKER = 8'h00;
  localparam logic [7:0] AS_PART  = 8'h01;
  localparam logic [7:0] AS_ZERO  = 8'h02;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

// ===== sv/pfci_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfci_ctrl: access sequencer
// Steps each accepted access through the array lookup and execution, and
// holds the block busy while an erase or the power-up clear sweeps the array.
// ----------------------------------------------------------------------------
module pfci_ctrl
  import pfci_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  seq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // The array is cleared to the erased value right after reset.
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = status.erase_req ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        if (status.sweep_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state_r == ST_IDLE) && start;
    cmd.mem_rd     = (state_r == ST_LOOK);
    cmd.exec       = (state_r == ST_EXEC);
    cmd.sweep_step = (state_r == ST_SWEEP);
    busy           = (state_r != ST_IDLE);
  end

endmodule

// ===== sv/pfci_dp.sv =====
// ----------------------------------------------------------------------------
// pfci_dp: flash datapath
// Holds the byte array, the configuration registers and the command mode,
// decodes one access against the current mode and runs the erase sweep.
// ----------------------------------------------------------------------------
module pfci_dp
  import pfci_pkg::*;
#(
  parameter int ADDR_BITS   = 19,
  parameter int SECTOR_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  req_t        in_req,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_strobe,
  output res_t        out_result
);

  localparam int DEPTH = 2 ** ADDR_BITS;
  localparam int SB    = (SECTOR_BITS < ADDR_BITS) ? SECTOR_BITS : ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] SECT_LOW = {ADDR_BITS{1'b1}} >> (ADDR_BITS - SB);

  logic [7:0] mem_q [0:DEPTH-1];

  req_t                 req_r;
  logic [7:0]           rdata_r;
  mode_t                mode_r, mode_nxt;
  logic [7:0]           last_prog_r, last_prog_nxt;
  logic                 modified_r, modified_nxt;
  logic [18:0]          u1_mask_r, u1_addr_r, u2_mask_r, u2_addr_r;
  logic [7:0]           maker_r, part_r;
  logic [ADDR_BITS-1:0] sweep_addr_r, sweep_end_r;
  logic                 out_strobe_r;
  res_t                 out_res_r;

  logic [ADDR_BITS+18:0] addr_ext;
  logic [ADDR_BITS-1:0]  req_cell;
  logic [ADDR_BITS-1:0]  sect_base;
  logic                  hit1, hit2;
  logic [7:0]            prog_val;
  logic [7:0]            rb;
  logic                  prog_wr, erase, chip;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [7:0]            mem_wdata;

  // Address bits above the array size are dropped.
  assign addr_ext  = {{ADDR_BITS{1'b0}}, req_r.bus_addr};
  assign req_cell  = addr_ext[ADDR_BITS-1:0];
  assign sect_base = req_cell & ~SECT_LOW;
  assign hit1      = (req_r.bus_addr & u1_mask_r) == u1_addr_r;
  assign hit2      = (req_r.bus_addr & u2_mask_r) == u2_addr_r;
  assign prog_val  = rdata_r & req_r.write_byte;

  always_comb begin
    mode_nxt      = mode_r;
    last_prog_nxt = last_prog_r;
    modified_nxt  = modified_r;
    rb            = '0;
    prog_wr       = 1'b0;
    erase         = 1'b0;
    chip          = 1'b0;
    if (!req_r.req_type) begin
      unique case (mode_r)
        M_AUTOSEL: begin
          unique case (req_r.bus_addr[7:0])
            AS_MAKER: rb = maker_r;
            AS_PART:  rb = part_r;
            AS_ZERO:  rb = '0;
            default:  rb = rdata_r;
          endcase
        end
        M_PROG_ERR: begin
          // Status byte: inverted data bit 7, bit 5 set, toggle bit never moves.
          rb = {~last_prog_r[7], 7'h20};
        end
        M_PROGRAMMED, M_CHIP_ERASE, M_SECT_ERASE, M_SUSPENDED: begin
          mode_nxt = M_READ;
          rb       = rdata_r;
        end
        default: begin
          rb = rdata_r;
        end
      endcase
    end else begin
      unique case (mode_r)
        M_READ: begin
          if (hit1 && req_r.write_byte == CMD_UNLOCK_A) mode_nxt = M_UNLK1;
        end
        M_UNLK1: begin
          mode_nxt = (hit2 && req_r.write_byte == CMD_UNLOCK_B) ? M_UNLK2 : M_READ;
        end
        M_UNLK2: begin
          priority if (hit1 && req_r.write_byte == CMD_AUTOSEL) mode_nxt = M_AUTOSEL;
          else if (hit1 && req_r.write_byte == CMD_PROGRAM) mode_nxt = M_PROG;
          else if (hit1 && req_r.write_byte == CMD_ERASE) mode_nxt = M_EUNLK1;
          else mode_nxt = M_READ;
        end
        M_PROG: begin
          prog_wr       = 1'b1;
          last_prog_nxt = req_r.write_byte;
          modified_nxt  = 1'b1;
          mode_nxt      = (prog_val == req_r.write_byte) ? M_PROGRAMMED : M_PROG_ERR;
        end
        M_EUNLK1: begin
          mode_nxt = (hit1 && req_r.write_byte == CMD_UNLOCK_A) ? M_EUNLK2 : M_READ;
        end
        M_EUNLK2: begin
          mode_nxt = (hit2 && req_r.write_byte == CMD_UNLOCK_B) ? M_ESELECT : M_READ;
        end
        M_ESELECT: begin
          priority if (hit1 && req_r.write_byte == CMD_CHIP) begin
            erase        = 1'b1;
            chip         = 1'b1;
            modified_nxt = 1'b1;
            mode_nxt     = M_CHIP_ERASE;
          end else if (req_r.write_byte == CMD_SECTOR) begin
            erase        = 1'b1;
            modified_nxt = 1'b1;
            mode_nxt     = M_SECT_ERASE;
          end else begin
            mode_nxt = M_READ;
          end
        end
        M_SECT_ERASE: begin
          if (req_r.write_byte == CMD_SUSPEND) mode_nxt = M_SUSPENDED;
        end
        M_SUSPENDED: begin
          if (req_r.write_byte == CMD_SECTOR) mode_nxt = M_SECT_ERASE;
        end
        M_AUTOSEL, M_PROG_ERR: begin
          if (req_r.write_byte == CMD_EXIT) mode_nxt = M_READ;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  assign mem_we    = cmd.sweep_step || (cmd.exec && prog_wr);
  assign mem_waddr = cmd.sweep_step ? sweep_addr_r : req_cell;
  assign mem_wdata = cmd.sweep_step ? ERASED_BYTE : prog_val;

  always_ff @(posedge clk) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd.mem_rd) rdata_r <= mem_q[req_cell];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_req;
    if (cmd.exec) begin
      out_res_r.read_byte <= rb;
      out_res_r.modified  <= modified_nxt;
      out_res_r.mode      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_READ;
      last_prog_r  <= '0;
      modified_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      sweep_addr_r <= '0;
      sweep_end_r  <= '1;
    end else begin
      out_strobe_r <= cmd.exec;
      if (cmd.exec) begin
        mode_r      <= mode_nxt;
        last_prog_r <= last_prog_nxt;
        modified_r  <= modified_nxt;
      end
      if (cmd.exec && erase) begin
        sweep_addr_r <= chip ? '0 : sect_base;
        sweep_end_r  <= chip ? '1 : (sect_base | SECT_LOW);
      end else if (cmd.sweep_step) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_mask_r <= 19'h007FF;
      u1_addr_r <= 19'h00555;
      u2_mask_r <= 19'h007FF;
      u2_addr_r <= 19'h002AA;
      maker_r   <= 8'h01;
      part_r    <= 8'hA4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_U1_MASK: u1_mask_r <= cfg_data;
        CFG_U1_ADDR: u1_addr_r <= cfg_data;
        CFG_U2_MASK: u2_mask_r <= cfg_data;
        CFG_U2_ADDR: u2_addr_r <= cfg_data;
        CFG_MAKER:   maker_r   <= cfg_data[7:0];
        CFG_PART:    part_r    <= cfg_data[7:0];
        default:     u1_mask_r <= u1_mask_r;
      endcase
    end
  end

  assign status.erase_req  = erase;
  assign status.sweep_last = (sweep_addr_r == sweep_end_r);
  assign out_strobe        = out_strobe_r;
  assign out_result        = out_res_r;

endmodule

// ===== sv/parallel_flash_command_interface_unit.sv =====
// ----------------------------------------------------------------------------
// parallel_flash_command_interface_unit: byte-wide NOR flash command model
// Top level joining the access sequencer and the flash datapath.
// ----------------------------------------------------------------------------
// Each access accepted on start (while busy is low) produces one result after
// the array read and the execute step, shown for a single cycle with out_strobe;
// the receiver must take it then. Each access steps through the array read, the
// execute step, and the cycle in which the result register is shown and the next
// access can already be captured. A chip erase then walks all 2**ADDR_BITS bytes
// and a sector erase 2**min(SECTOR_BITS, ADDR_BITS) bytes of the array, one
// array byte written per cycle through the single write port; the erase result
// is shown at the start of that walk and busy stays high to its end. After reset
// the array is cleared the same way, with busy high. Configuration writes are
// always taken.
module parallel_flash_command_interface_unit
  import pfci_pkg::*;
#(
  parameter int ADDR_BITS   = 19,
  parameter int SECTOR_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  output logic        out_strobe,
  output res_t        out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [18:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pfci_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pfci_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

// ===== sv/pfci_checker.sv =====
// ----------------------------------------------------------------------------
// pfci_checker: port-level checks of the flash command interface
// Watches the access and result ports of the top level over time.
// ----------------------------------------------------------------------------
module pfci_checker
  import pfci_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input res_t out_result
);

  // An accepted access makes the block busy once the sequencer state register takes it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted beat");

  // Every accepted access produces a result strobe.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_strobe)
    else $error("result beat missing three cycles after an accepted beat");

  // Results of back-to-back accesses cannot come in adjacent cycles.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // The reported command mode is always a defined mode.
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_result.mode <= M_SUSPENDED)
    else $error("result beat carries an undefined command mode");

endmodule

bind parallel_flash_command_interface_unit pfci_checker u_pfci_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the parallel flash command interface
// Drives byte accesses as well-formed command sequences (unlock, autoselect,
// program, erase, suspend and resume) mixed with broken sequences and bus
// noise. A behavioral flash model predicts every result beat, which is
// checked field by field. Five configuration phases cover the unlock
// compare and ID registers, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import pfci_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int ARRAY_BYTES  = 1 << 19;
  localparam int SECTOR_BYTES = 1 << 16;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 8_000_000;

  localparam logic [18:0] DEF_UL_MASK = 19'h007FF;
  localparam logic [18:0] DEF_UL1     = 19'h00555;
  localparam logic [18:0] DEF_UL2     = 19'h002AA;
  localparam logic [7:0]  DEF_MAKER   = 8'h01;
  localparam logic [7:0]  DEF_PART    = 8'hA4;
  localparam logic [7:0]  STATUS_BASE = 8'h20;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        in_req;
  logic        out_strobe;
  res_t        out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [18:0] cfg_data;

  parallel_flash_command_interface_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Flash model state and its copy of the configuration.
  bit [7:0]    flash_img [0:ARRAY_BYTES-1];
  mode_t       cmd_mode;
  logic [7:0]  last_pgm_byte;
  logic        dirty;
  logic [18:0] ul1_mask, ul1_match, ul2_mask, ul2_match;
  logic [7:0]  id_maker, id_device;

  req_t        access_queue[$];
  res_t        expected_results[$];
  logic [18:0] cell_pool [POOL_SIZE];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  bit          quiet = 1'b0;
  bit          gaps_on = 1'b1;
  int          sector_budget = 6;

  function automatic bit hits1(logic [18:0] a);
    return (a & ul1_mask) == ul1_match;
  endfunction

  function automatic bit hits2(logic [18:0] a);
    return (a & ul2_mask) == ul2_match;
  endfunction

  function automatic res_t flash_access(req_t acc);
    res_t        r;
    logic [18:0] a;
    logic [7:0]  v;
    logic [7:0]  nv;
    int          base;
    a = acc.bus_addr;
    v = acc.write_byte;
    r = '0;
    if (acc.req_type == ACC_WRITE) begin
      case (cmd_mode)
        M_READ: if (hits1(a) && v == CMD_UNLOCK_A) cmd_mode = M_UNLK1;
        M_UNLK1: cmd_mode = (hits2(a) && v == CMD_UNLOCK_B) ? M_UNLK2 : M_READ;
        M_UNLK2: begin
          if (hits1(a) && v == CMD_AUTOSEL) cmd_mode = M_AUTOSEL;
          else if (hits1(a) && v == CMD_PROGRAM) cmd_mode = M_PROG;
          else if (hits1(a) && v == CMD_ERASE) cmd_mode = M_EUNLK1;
          else cmd_mode = M_READ;
        end
        M_PROG: begin
          nv = flash_img[a] & v;
          last_pgm_byte = v;
          flash_img[a] = nv;
          dirty = 1'b1;
          cmd_mode = (nv == v) ? M_PROGRAMMED : M_PROG_ERR;
        end
        M_EUNLK1: cmd_mode = (hits1(a) && v == CMD_UNLOCK_A) ? M_EUNLK2 : M_READ;
        M_EUNLK2: cmd_mode = (hits2(a) && v == CMD_UNLOCK_B) ? M_ESELECT : M_READ;
        M_ESELECT: begin
          if (hits1(a) && v == CMD_CHIP) begin
            foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
            dirty = 1'b1;
            cmd_mode = M_CHIP_ERASE;
          end else if (v == CMD_SECTOR) begin
            base = int'(a) & ~(SECTOR_BYTES - 1);
            for (int i = 0; i < SECTOR_BYTES; i++) flash_img[base + i] = ERASED_BYTE;
            dirty = 1'b1;
            cmd_mode = M_SECT_ERASE;
          end else begin
            cmd_mode = M_READ;
          end
        end
        M_SECT_ERASE: if (v == CMD_SUSPEND) cmd_mode = M_SUSPENDED;
        M_SUSPENDED: if (v == CMD_SECTOR) cmd_mode = M_SECT_ERASE;
        M_AUTOSEL, M_PROG_ERR: if (v == CMD_EXIT) cmd_mode = M_READ;
        default: ;
      endcase
    end else begin
      case (cmd_mode)
        M_AUTOSEL: begin
          case (a[7:0])
            AS_MAKER: r.read_byte = id_maker;
            AS_PART:  r.read_byte = id_device;
            AS_ZERO:  r.read_byte = 8'h00;
            default:  r.read_byte = flash_img[a];
          endcase
        end
        M_PROG_ERR: r.read_byte = {~last_pgm_byte[7], 7'b0} | STATUS_BASE;
        M_PROGRAMMED, M_CHIP_ERASE, M_SECT_ERASE, M_SUSPENDED: begin
          cmd_mode = M_READ;
          r.read_byte = flash_img[a];
        end
        default: r.read_byte = flash_img[a];
      endcase
    end
    r.modified = dirty;
    r.mode = cmd_mode;
    return r;
  endfunction

  // ---- stimulus helpers ----

  function automatic void queue_access(logic wr, logic [18:0] a, logic [7:0] d);
    req_t acc;
    acc.req_type = wr;
    acc.bus_addr = a;
    acc.write_byte = d;
    access_queue.push_back(acc);
  endfunction

  // Random data that can never start a chip or sector erase by accident.
  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom); while (v == CMD_CHIP || v == CMD_SECTOR);
    return v;
  endfunction

  function automatic logic [18:0] unlock1_hit();
    return (19'($urandom) & ~ul1_mask) | (ul1_match & ul1_mask);
  endfunction

  function automatic logic [18:0] unlock2_hit();
    return (19'($urandom) & ~ul2_mask) | (ul2_match & ul2_mask);
  endfunction

  function automatic logic [18:0] pool_addr();
    if ($urandom_range(0, 3) != 0) return cell_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 19'($urandom);
  endfunction

  // A read in the middle of a sequence must leave the mode alone.
  function automatic void maybe_probe();
    if ($urandom_range(0, 7) == 0) queue_access(ACC_READ, pool_addr(), 8'($urandom));
  endfunction

  function automatic void queue_unlock();
    queue_access(ACC_WRITE, unlock1_hit(), CMD_UNLOCK_A);
    maybe_probe();
    queue_access(ACC_WRITE, unlock2_hit(), CMD_UNLOCK_B);
    maybe_probe();
  endfunction

  function automatic void queue_program();
    queue_unlock();
    queue_access(ACC_WRITE, unlock1_hit(), CMD_PROGRAM);
    maybe_probe();
    queue_access(ACC_WRITE, pool_addr(), plain_byte());
    if ($urandom_range(0, 3) == 0) queue_access(ACC_WRITE, pool_addr(), plain_byte());
    repeat ($urandom_range(1, 2)) queue_access(ACC_READ, pool_addr(), 8'($urandom));
    if ($urandom_range(0, 3) != 0) queue_access(ACC_WRITE, 19'($urandom), CMD_EXIT);
  endfunction

  function automatic void queue_autoselect();
    logic [7:0] offs;
    queue_unlock();
    queue_access(ACC_WRITE, unlock1_hit(), CMD_AUTOSEL);
    repeat ($urandom_range(2, 5)) begin
      case ($urandom_range(0, 3))
        0: offs = AS_MAKER;
        1: offs = AS_PART;
        2: offs = AS_ZERO;
        default: offs = 8'($urandom);
      endcase
      queue_access(ACC_READ, {11'($urandom), offs}, 8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) queue_access(ACC_WRITE, pool_addr(), plain_byte());
    if ($urandom_range(0, 7) != 0) queue_access(ACC_WRITE, 19'($urandom), CMD_EXIT);
  endfunction

  function automatic void queue_erase();
    queue_unlock();
    queue_access(ACC_WRITE, unlock1_hit(), CMD_ERASE);
    maybe_probe();
    queue_access(ACC_WRITE, unlock1_hit(), CMD_UNLOCK_A);
    maybe_probe();
    queue_access(ACC_WRITE, unlock2_hit(), CMD_UNLOCK_B);
    maybe_probe();
    // Sector erases cost a full sector walk each, so only a handful run.
    if (sector_budget > 0 && (sector_budget == 6 || $urandom_range(0, 2) == 0)) begin
      sector_budget--;
      queue_access(ACC_WRITE, 19'($urandom), CMD_SECTOR);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 2))
          0: queue_access(ACC_WRITE, pool_addr(), CMD_SUSPEND);
          1: queue_access(ACC_WRITE, pool_addr(), CMD_SECTOR);
          default: queue_access(ACC_WRITE, pool_addr(), plain_byte());
        endcase
      end
      queue_access(ACC_READ, pool_addr(), 8'($urandom));
    end else begin
      queue_access(ACC_WRITE, unlock1_hit(), plain_byte());
    end
  endfunction

  function automatic void queue_broken();
    int bad_step;
    bad_step = $urandom_range(0, 2);
    queue_access(ACC_WRITE, (bad_step == 0) ? 19'($urandom) : unlock1_hit(),
                 (bad_step == 0 && $urandom_range(0, 1)) ? plain_byte() : CMD_UNLOCK_A);
    queue_access(ACC_WRITE, unlock2_hit(), (bad_step == 1) ? plain_byte() : CMD_UNLOCK_B);
    queue_access(ACC_WRITE, unlock1_hit(), plain_byte());
    if ($urandom_range(0, 1)) queue_access(ACC_READ, pool_addr(), 8'($urandom));
  endfunction

  function automatic void queue_random_part(int count);
    int target;
    target = access_queue.size() + count;
    while (access_queue.size() < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:     queue_program();
        6, 7, 8:              queue_autoselect();
        9, 10:                queue_erase();
        11, 12, 13:           queue_broken();
        default: begin
          repeat ($urandom_range(1, 3))
            queue_access($urandom_range(0, 1) ? ACC_WRITE : ACC_READ,
                         ($urandom_range(0, 1)) ? pool_addr() : 19'($urandom), plain_byte());
        end
      endcase
    end
  endfunction

  function automatic void queue_directed();
    queue_access(ACC_READ, 19'h7FFFF, 8'hFF);
    // Autoselect IDs, then exit.
    queue_access(ACC_WRITE, DEF_UL1, CMD_UNLOCK_A);
    queue_access(ACC_WRITE, DEF_UL2, CMD_UNLOCK_B);
    queue_access(ACC_WRITE, DEF_UL1, CMD_AUTOSEL);
    queue_access(ACC_READ, 19'h00100, 8'h00);
    queue_access(ACC_READ, 19'h7FF01, 8'h00);
    queue_access(ACC_READ, 19'h00002, 8'h00);
    queue_access(ACC_WRITE, 19'h7FFFF, CMD_EXIT);
    // A good program, then a read that leaves the done state.
    queue_access(ACC_WRITE, DEF_UL1, CMD_UNLOCK_A);
    queue_access(ACC_WRITE, DEF_UL2, CMD_UNLOCK_B);
    queue_access(ACC_WRITE, DEF_UL1, CMD_PROGRAM);
    queue_access(ACC_WRITE, 19'h7FFFF, 8'h00);
    queue_access(ACC_READ, 19'h7FFFF, 8'h00);
    // Programming a cleared byte fails; the status read shows bit 7 inverted.
    queue_access(ACC_WRITE, DEF_UL1, CMD_UNLOCK_A);
    queue_access(ACC_WRITE, DEF_UL2, CMD_UNLOCK_B);
    queue_access(ACC_WRITE, DEF_UL1, CMD_PROGRAM);
    queue_access(ACC_WRITE, 19'h7FFFF, 8'h7F);
    queue_access(ACC_READ, 19'h00000, 8'h00);
    queue_access(ACC_WRITE, 19'h00000, CMD_EXIT);
    // Chip erase; a write after it is ignored.
    queue_access(ACC_WRITE, DEF_UL1, CMD_UNLOCK_A);
    queue_access(ACC_WRITE, DEF_UL2, CMD_UNLOCK_B);
    queue_access(ACC_WRITE, DEF_UL1, CMD_ERASE);
    queue_access(ACC_WRITE, DEF_UL1, CMD_UNLOCK_A);
    queue_access(ACC_WRITE, DEF_UL2, CMD_UNLOCK_B);
    queue_access(ACC_WRITE, DEF_UL1, CMD_CHIP);
    queue_access(ACC_WRITE, 19'h00000, 8'h00);
    queue_access(ACC_READ, 19'h7FFFF, 8'h00);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_U1_MASK: ul1_mask  = val;
      CFG_U1_ADDR: ul1_match = val;
      CFG_U2_MASK: ul2_mask  = val;
      CFG_U2_ADDR: ul2_match = val;
      CFG_MAKER:   id_maker  = val[7:0];
      CFG_PART:    id_device = val[7:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (access_queue.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    // An erase keeps the block busy long after its result beat.
    while (busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---- driver ----
  always @(posedge clk) begin : drive
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) expected_results.push_back(flash_access(in_req));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (access_queue.size() != 0) begin
          in_req <= access_queue.pop_front();
          start  <= 1'b1;
          if (gaps_on) begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            if (!quiet && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 18);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  always @(posedge clk) begin : watch
    res_t want;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: read_byte %0h modified %0b mode %0d",
               out_result.read_byte, out_result.modified, out_result.mode);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_result.read_byte !== want.read_byte) begin
          $error("read_byte: expected %0h, actual %0h", want.read_byte, out_result.read_byte);
          fail_count++;
        end
        if (out_result.modified !== want.modified) begin
          $error("modified: expected %0b, actual %0b", want.modified, out_result.modified);
          fail_count++;
        end
        if (out_result.mode !== want.mode) begin
          $error("mode: expected %0d, actual %0d", want.mode, out_result.mode);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : run
    logic [18:0] m;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_U1_MASK;
    cfg_data  = '0;
    foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
    cmd_mode      = M_READ;
    last_pgm_byte = 8'h00;
    dirty         = 1'b0;
    ul1_mask  = DEF_UL_MASK;
    ul1_match = DEF_UL1;
    ul2_mask  = DEF_UL_MASK;
    ul2_match = DEF_UL2;
    id_maker  = DEF_MAKER;
    id_device = DEF_PART;
    cell_pool[0] = 19'h00000;
    cell_pool[1] = 19'h7FFFF;
    for (int i = 2; i < POOL_SIZE; i++) cell_pool[i] = 19'($urandom);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    // Reset values of the registers.
    queue_directed();
    queue_random_part(480);
    drain();

    // Full-width unlock compares, ID extremes.
    write_reg(CFG_U1_MASK, 19'h7FFFF);
    write_reg(CFG_U1_ADDR, 19'($urandom));
    write_reg(CFG_U2_MASK, 19'h7FFFF);
    write_reg(CFG_U2_ADDR, 19'($urandom));
    write_reg(CFG_MAKER, 19'h00000);
    write_reg(CFG_PART, 19'h000FF);
    queue_random_part(350);
    drain();

    // Empty masks: every address matches both unlock compares.
    write_reg(CFG_U1_MASK, 19'h00000);
    write_reg(CFG_U1_ADDR, 19'h00000);
    write_reg(CFG_U2_MASK, 19'h00000);
    write_reg(CFG_U2_ADDR, 19'h00000);
    write_reg(CFG_MAKER, 19'h000FF);
    write_reg(CFG_PART, 19'h7FF00);
    queue_random_part(330);
    drain();

    // Random masks; ID writes carry junk above bit 7.
    m = 19'($urandom);
    write_reg(CFG_U1_MASK, m);
    write_reg(CFG_U1_ADDR, 19'($urandom) & m);
    m = 19'($urandom);
    write_reg(CFG_U2_MASK, m);
    write_reg(CFG_U2_ADDR, 19'($urandom) & m);
    write_reg(CFG_MAKER, 19'($urandom));
    write_reg(CFG_PART, 19'($urandom));
    queue_random_part(330);
    drain();

    // Back to reset values, back-to-back accesses.
    write_reg(CFG_U1_MASK, DEF_UL_MASK);
    write_reg(CFG_U1_ADDR, DEF_UL1);
    write_reg(CFG_U2_MASK, DEF_UL_MASK);
    write_reg(CFG_U2_ADDR, DEF_UL2);
    write_reg(CFG_MAKER, {11'h000, DEF_MAKER});
    write_reg(CFG_PART, {11'h000, DEF_PART});
    gaps_on = 1'b0;
    queue_random_part(300);
    drain();
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
